@@ hw/rtl/gbmeo_pkg.sv @@
// ----------------------------------------------------------------------------
// gbmeo_pkg
// Shared types, constants and tables of the GBM European option pricer.
// ----------------------------------------------------------------------------
package gbmeo_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_OPTION_IS_CALL  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STRIKE_PRICE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPOT_PRICE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_PER_STEP  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VOLATILITY      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_PATH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_PATH_COUNT      = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd7;

  // Fixed-point constants, Q.30
  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [29:0] LN2_Q30   = 30'd744261118;
  localparam logic [30:0] ONE_Q30   = 31'd1073741824;

  localparam logic [3:0]  SER_TERMS = 4'd14;
  localparam int unsigned TOTAL_W   = 56;

  typedef struct packed {
    logic        option_is_call;
    logic [31:0] strike_price;
    logic [31:0] spot_price;
    logic [23:0] drift_per_step;
    logic [17:0] volatility;
    logic [12:0] steps_per_path;
    logic [20:0] path_count;
    logic [16:0] discount_factor;
  } cfg_t;

  // Controller to datapath commands
  typedef struct packed {
    logic step;
    logic exp_y;
    logic exp_t;
    logic ser_mul;
    logic ser_rec;
    logic ser_fix;
    logic price_mul;
    logic price_shift;
    logic payoff;
    logic div_start;
    logic pv_mul;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic path_end;
    logic ser_last;
    logic batch_end;
    logic div_done;
    logic out_free;
  } status_t;

  // floor(2^32 / n) for the series divisors 1..14
  function automatic logic [32:0] recip_q32(input logic [3:0] n);
    logic [32:0] r;
    case (n)
      4'd1:    r = 33'd4294967296;
      4'd2:    r = 33'd2147483648;
      4'd3:    r = 33'd1431655765;
      4'd4:    r = 33'd1073741824;
      4'd5:    r = 33'd858993459;
      4'd6:    r = 33'd715827882;
      4'd7:    r = 33'd613566756;
      4'd8:    r = 33'd536870912;
      4'd9:    r = 33'd477218588;
      4'd10:   r = 33'd429496729;
      4'd11:   r = 33'd390451572;
      4'd12:   r = 33'd357913941;
      4'd13:   r = 33'd330382099;
      4'd14:   r = 33'd306783378;
      default: r = 33'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hw/rtl/gbm_european_option_pricer.sv @@
// ----------------------------------------------------------------------------
// gbm_european_option_pricer
// Monte Carlo pricer of a European call or put over GBM paths, fixed point.
// ----------------------------------------------------------------------------
// Feed one scaled normal noise sample per item. Within a path the block can
// take the next item right after the last: the volatility-times-noise multiply
// and the saturating add into the log return close in the accept cycle. The
// item that ends a path holds the input while the shared sequencer works out
// spot * exp(sum): one log2(e) multiply, one ln2 multiply, then a 14-term
// series with a multiply, a reciprocal multiply and a correction per term,
// then the price multiply, shift and payoff. The path that ends a batch then
// also runs the bit-serial divider that forms the mean payoff, followed by
// the discount multiply. A result item is emitted once per batch; the block
// waits for the result register to drain before loading a new one.
// Configuration writes take effect at once and never clear a running path or
// batch.
// ----------------------------------------------------------------------------
module gbm_european_option_pricer
  import gbmeo_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 4096,
  parameter int unsigned MAX_PATHS = 1048576
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [23:0]    in_noise_sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [31:0]           out_present_value,
  output logic                  out_saturated,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t    cfg_r;
  cmd_t    cmd;
  status_t status;

  // Configuration registers; write them only while idle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.option_is_call  <= 1'b1;
      cfg_r.strike_price    <= 32'd6553600;
      cfg_r.spot_price      <= 32'd6553600;
      cfg_r.drift_per_step  <= 24'd47;
      cfg_r.volatility      <= 18'd13107;
      cfg_r.steps_per_path  <= 13'd1000;
      cfg_r.path_count      <= 21'd5000;
      cfg_r.discount_factor <= 17'd62339;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OPTION_IS_CALL:  cfg_r.option_is_call  <= cfg_data[0];
        REG_STRIKE_PRICE:    cfg_r.strike_price    <= cfg_data;
        REG_SPOT_PRICE:      cfg_r.spot_price      <= cfg_data;
        REG_DRIFT_PER_STEP:  cfg_r.drift_per_step  <= cfg_data[23:0];
        REG_VOLATILITY:      cfg_r.volatility      <= cfg_data[17:0];
        REG_STEPS_PER_PATH:  cfg_r.steps_per_path  <= cfg_data[12:0];
        REG_PATH_COUNT:      cfg_r.path_count      <= cfg_data[20:0];
        REG_DISCOUNT_FACTOR: cfg_r.discount_factor <= cfg_data[16:0];
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  // Sequencer: accept samples, step through path and batch ends.
  gbmeo_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  // Arithmetic and the result register.
  gbmeo_dp #(
    .MAX_STEPS(MAX_STEPS),
    .MAX_PATHS(MAX_PATHS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .status           (status),
    .in_noise_sample  (in_noise_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_present_value(out_present_value),
    .out_saturated    (out_saturated)
  );

endmodule

@@ hw/rtl/gbmeo_div.sv @@
// ----------------------------------------------------------------------------
// gbmeo_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gbmeo_div #(
  parameter int unsigned NW = 56,
  parameter int unsigned DW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [NW-1:0] quo,
  output logic          done
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] quo_r, quo_nxt;
  logic [DW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   shifted;
  logic [DW:0]   diff;

  assign shifted = {rem_r, quo_r[NW-1]};
  assign diff    = shifted - {1'b0, den_r};

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = num;
      rem_nxt  = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (shifted >= {1'b0, den_r}) begin
        rem_nxt = diff[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DW-1:0];
        quo_nxt = {quo_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    if (start) begin
      den_r <= den;
    end
  end

  assign quo  = quo_r;
  assign done = done_r;

endmodule

@@ hw/rtl/gbmeo_ctrl.sv @@
// ----------------------------------------------------------------------------
// gbmeo_ctrl
// Sequencer: sample steps, path-end exponential, payoff, batch-end average.
// ----------------------------------------------------------------------------
module gbmeo_ctrl
  import gbmeo_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXP_Y,
    S_EXP_T,
    S_SER_MUL,
    S_SER_REC,
    S_SER_FIX,
    S_PRICE_MUL,
    S_PRICE_SHIFT,
    S_PAYOFF,
    S_DIV_START,
    S_DIV_WAIT,
    S_PV_MUL,
    S_PV_OUT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.step = 1'b1;
          if (status.path_end) begin
            state_nxt = S_EXP_Y;
          end
        end
      end
      S_EXP_Y: begin
        cmd.exp_y = 1'b1;
        state_nxt = S_EXP_T;
      end
      S_EXP_T: begin
        cmd.exp_t = 1'b1;
        state_nxt = S_SER_MUL;
      end
      S_SER_MUL: begin
        cmd.ser_mul = 1'b1;
        state_nxt   = S_SER_REC;
      end
      S_SER_REC: begin
        cmd.ser_rec = 1'b1;
        state_nxt   = S_SER_FIX;
      end
      S_SER_FIX: begin
        cmd.ser_fix = 1'b1;
        state_nxt   = status.ser_last ? S_PRICE_MUL : S_SER_MUL;
      end
      S_PRICE_MUL: begin
        cmd.price_mul = 1'b1;
        state_nxt     = S_PRICE_SHIFT;
      end
      S_PRICE_SHIFT: begin
        cmd.price_shift = 1'b1;
        state_nxt       = S_PAYOFF;
      end
      S_PAYOFF: begin
        cmd.payoff = 1'b1;
        state_nxt  = status.batch_end ? S_DIV_START : S_IDLE;
      end
      S_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = S_PV_MUL;
        end
      end
      S_PV_MUL: begin
        cmd.pv_mul = 1'b1;
        state_nxt  = S_PV_OUT;
      end
      S_PV_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ hw/rtl/gbmeo_dp.sv @@
// ----------------------------------------------------------------------------
// gbmeo_dp
// Datapath: log-return accumulator, exp series, payoff total, result register.
// ----------------------------------------------------------------------------
module gbmeo_dp
  import gbmeo_pkg::*;
#(
  parameter int unsigned MAX_STEPS = 4096,
  parameter int unsigned MAX_PATHS = 1048576
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic signed [23:0] in_noise_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_present_value,
  output logic               out_saturated
);

  localparam int unsigned SCW = $clog2(MAX_STEPS + 1);
  localparam int unsigned PCW = $clog2(MAX_PATHS + 1);

  // ---- step and path limits ----
  logic [SCW-1:0] lim_steps;
  logic [PCW-1:0] lim_paths;

  always_comb begin
    if (cfg.steps_per_path == '0) begin
      lim_steps = SCW'(1);
    end else if (32'(cfg.steps_per_path) > 32'(MAX_STEPS)) begin
      lim_steps = SCW'(MAX_STEPS);
    end else begin
      lim_steps = SCW'(cfg.steps_per_path);
    end
    if (cfg.path_count == '0) begin
      lim_paths = PCW'(1);
    end else if (32'(cfg.path_count) > 32'(MAX_PATHS)) begin
      lim_paths = PCW'(MAX_PATHS);
    end else begin
      lim_paths = PCW'(cfg.path_count);
    end
  end

  // ---- per-sample accumulate ----
  logic signed [31:0] lrs_r;
  logic [SCW-1:0]     step_idx_r;
  logic [SCW:0]       step_inc;
  logic signed [42:0] vn_prod;
  logic signed [33:0] sum_w;
  logic signed [31:0] sum_sat;

  assign vn_prod  = $signed({1'b0, cfg.volatility}) * in_noise_sample;
  assign sum_w    = {{2{lrs_r[31]}}, lrs_r} + {{7{vn_prod[42]}}, vn_prod[42:16]}
                  + {{10{cfg.drift_per_step[23]}}, cfg.drift_per_step};
  assign step_inc = {1'b0, step_idx_r} + 1'b1;

  always_comb begin
    if (!sum_w[33] && (sum_w[32] || sum_w[31])) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum_w[33] && !(sum_w[32] && sum_w[31])) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum_w[31:0];
    end
  end

  assign status.path_end = (step_inc >= {1'b0, lim_steps});

  // ---- exponential: 2^k * 2^f, 2^f by series ----
  logic signed [63:0] y_w;
  logic signed [13:0] k_r;
  logic [29:0]        f_r;
  logic [59:0]        ft_w;
  logic [29:0]        t_r;
  logic [60:0]        at_w;
  logic [30:0]        a_r;
  logic [63:0]        qe_w;
  logic [30:0]        qe_r;
  logic [34:0]        qn_w;
  logic [34:0]        rem_w;
  logic [30:0]        q_fix;
  logic [30:0]        term_r;
  logic [31:0]        m_r;
  logic [3:0]         n_r;

  assign y_w   = lrs_r * $signed({1'b0, LOG2E_Q30});
  assign ft_w  = f_r * LN2_Q30;
  assign at_w  = term_r * t_r;
  assign qe_w  = a_r * recip_q32(n_r);
  assign qn_w  = qe_r * n_r;
  assign rem_w = {4'd0, a_r} - qn_w;
  assign q_fix = (rem_w >= 35'(n_r)) ? qe_r + 1'b1 : qe_r;

  assign status.ser_last = (n_r == SER_TERMS);

  // ---- terminal price ----
  logic [63:0]        prod_r;
  logic signed [14:0] sh;
  logic [14:0]        lsh;
  logic [63:0]        shr_w;
  logic [31:0]        price_w;
  logic               price_sat_w;
  logic [31:0]        price_r;
  logic               price_sat_r;

  assign sh  = 15'sd30 - {k_r[13], k_r};
  assign lsh = 15'd0 - sh;

  always_comb begin
    price_w     = '0;
    price_sat_w = 1'b0;
    shr_w       = '0;
    if (prod_r == '0) begin
      price_w = '0;
    end else if (sh >= 15'sd64) begin
      price_w = '0;
    end else if (sh > 15'sd0) begin
      shr_w = prod_r >> sh[5:0];
      if (shr_w[63:32] != '0) begin
        price_sat_w = 1'b1;
        price_w     = '1;
      end else begin
        price_w = shr_w[31:0];
      end
    end else if (sh < 15'sd0) begin
      if (lsh >= 15'd32) begin
        price_sat_w = 1'b1;
        price_w     = '1;
      end else if (prod_r > {32'd0, 32'hFFFFFFFF >> lsh[4:0]}) begin
        price_sat_w = 1'b1;
        price_w     = '1;
      end else begin
        shr_w   = prod_r << lsh[4:0];
        price_w = shr_w[31:0];
      end
    end else begin
      if (prod_r[63:32] != '0) begin
        price_sat_w = 1'b1;
        price_w     = '1;
      end else begin
        price_w = prod_r[31:0];
      end
    end
  end

  // ---- payoff and batch totals ----
  logic [31:0]        payoff_w;
  logic [TOTAL_W:0]   tot_sum;
  logic [TOTAL_W-1:0] total_r;
  logic               sat_seen_r;
  logic [PCW-1:0]     paths_r;
  logic [PCW:0]       paths_inc;
  logic [PCW-1:0]     paths_div_r;

  always_comb begin
    if (cfg.option_is_call) begin
      payoff_w = (price_r > cfg.strike_price) ? price_r - cfg.strike_price : '0;
    end else begin
      payoff_w = (cfg.strike_price > price_r) ? cfg.strike_price - price_r : '0;
    end
  end

  assign tot_sum   = {1'b0, total_r} + (TOTAL_W + 1)'(payoff_w);
  assign paths_inc = {1'b0, paths_r} + 1'b1;

  assign status.batch_end = (paths_inc >= {1'b0, lim_paths});

  // ---- batch mean and discount ----
  logic [TOTAL_W-1:0] mean_w;
  logic [44:0]        phi_r;
  logic [44:0]        plo_r;
  logic [73:0]        full_w;
  logic [57:0]        pv_w;
  logic               pv_sat;

  gbmeo_div #(
    .NW(TOTAL_W),
    .DW(PCW)
  ) u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num  (total_r),
    .den  (paths_div_r),
    .quo  (mean_w),
    .done (status.div_done)
  );

  assign full_w = {1'b0, phi_r, 28'd0} + {29'd0, plo_r};
  assign pv_w   = full_w[73:16];
  assign pv_sat = (pv_w[57:32] != '0);

  // ---- result register ----
  logic        out_valid_r;
  logic [31:0] out_pv_r;
  logic        out_sat_r;

  assign status.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lrs_r       <= '0;
      step_idx_r  <= '0;
      paths_r     <= '0;
      total_r     <= '0;
      sat_seen_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step) begin
        lrs_r      <= sum_sat;
        step_idx_r <= status.path_end ? '0 : step_inc[SCW-1:0];
      end
      if (cmd.exp_y) begin
        lrs_r <= '0;
      end
      if (cmd.payoff) begin
        if (tot_sum[TOTAL_W]) begin
          total_r <= '1;
        end else begin
          total_r <= tot_sum[TOTAL_W-1:0];
        end
        if (tot_sum[TOTAL_W] || price_sat_r) begin
          sat_seen_r <= 1'b1;
        end
        paths_r <= status.batch_end ? '0 : paths_inc[PCW-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
        total_r     <= '0;
        sat_seen_r  <= 1'b0;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (cmd.exp_y) begin
      k_r <= y_w[63:50];
      f_r <= y_w[49:20];
    end
    if (cmd.exp_t) begin
      t_r    <= ft_w[59:30];
      term_r <= ONE_Q30;
      m_r    <= {1'b0, ONE_Q30};
      n_r    <= 4'd1;
    end
    if (cmd.ser_mul) begin
      a_r <= at_w[60:30];
    end
    if (cmd.ser_rec) begin
      qe_r <= qe_w[62:32];
    end
    if (cmd.ser_fix) begin
      term_r <= q_fix;
      m_r    <= m_r + {1'b0, q_fix};
      n_r    <= n_r + 1'b1;
    end
    if (cmd.price_mul) begin
      prod_r <= cfg.spot_price * m_r;
    end
    if (cmd.price_shift) begin
      price_r     <= price_w;
      price_sat_r <= price_sat_w;
    end
    if (cmd.payoff) begin
      paths_div_r <= paths_inc[PCW-1:0];
    end
    if (cmd.pv_mul) begin
      phi_r <= mean_w[55:28] * cfg.discount_factor;
      plo_r <= mean_w[27:0] * cfg.discount_factor;
    end
    if (cmd.out_load) begin
      out_pv_r  <= pv_sat ? 32'hFFFFFFFF : pv_w[31:0];
      out_sat_r <= sat_seen_r || pv_sat;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_present_value = out_pv_r;
  assign out_saturated     = out_sat_r;

endmodule

@@ hw/rtl/gbmeo_checker.sv @@
// ----------------------------------------------------------------------------
// gbmeo_checker
// Port-level checks of the pricer, bound to the top level.
// ----------------------------------------------------------------------------
module gbmeo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_present_value,
  input logic        out_saturated
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_present_value)
      && $stable(out_saturated))
    else $error("stalled result changed");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A result is loaded only from the batch-end sequence, never while sampling.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared while accepting samples");

  // A result leaves only through a handshake.
  assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result dropped without handshake");

endmodule

bind gbm_european_option_pricer gbmeo_checker u_gbmeo_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_present_value(out_present_value),
  .out_saturated    (out_saturated)
);

@@ dv/tb_gbm_european_option_pricer.sv @@
// ----------------------------------------------------------------------------
// tb_gbm_european_option_pricer
// Self-checking bench: noise items drive a bit-exact pricer model, results
// are checked in order against the batch values it predicts.
// ----------------------------------------------------------------------------
module tb_gbm_european_option_pricer;
  import gbmeo_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LOG2E_FX = 64'd1549082005;
  localparam longint unsigned LN2_FX   = 64'd744261118;
  localparam longint unsigned ONE_FX   = 64'd1073741824;
  localparam longint unsigned TOTAL_CAP = (64'd1 << 56) - 64'd1;
  localparam int STEP_CAP = 4096;
  localparam int PATH_CAP = 1048576;
  // Cycles a path end plus a batch end may keep the block busy, with margin.
  localparam int SETTLE_CYCLES = 250;

  typedef struct {
    bit [31:0] present_value;
    bit        saturated;
  } batch_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic signed [23:0]    in_noise_sample = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [31:0]           out_present_value;
  logic                  out_saturated;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Register shadow, reset values.
  bit        opt_call   = 1'b1;
  bit [31:0] strike     = 32'd6553600;
  bit [31:0] spot       = 32'd6553600;
  bit [23:0] drift      = 24'd47;
  bit [17:0] vol        = 18'd13107;
  bit [12:0] steps_cfg  = 13'd1000;
  bit [20:0] paths_cfg  = 21'd5000;
  bit [16:0] discount   = 17'd62339;

  // Running pricer state.
  int          log_sum;
  int unsigned step_cnt;
  int unsigned path_cnt;
  bit [63:0]   payoff_acc;
  bit          sat_sticky;

  batch_result_t pv_expected_q[$];
  int  fail_count;
  bit  sender_quiet;   // no gaps between input items
  bit  sink_quiet;     // result side always ready
  int  sink_stall_left;

  gbm_european_option_pricer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_noise_sample  (in_noise_sample),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_present_value(out_present_value),
    .out_saturated    (out_saturated),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #5 clk = ~clk;

  // spot * exp(x): x in Q12.20, spot and result in Q16.16, saturating.
  function automatic bit [31:0] terminal_price(input bit [31:0] s0, input int x,
                                               output bit sat);
    longint    y;
    bit [63:0] u, f, t, term, m, prod;
    longint    k, sh;
    sat  = 1'b0;
    y    = longint'(x) * longint'(LOG2E_FX);
    u    = 64'(y) + (64'd1 << 62);
    k    = longint'(u >> 50) - 4096;
    f    = (u & ((64'd1 << 50) - 64'd1)) >> 20;
    t    = (f * LN2_FX) >> 30;
    term = ONE_FX;
    m    = ONE_FX;
    for (int n = 1; n <= 14; n++) begin
      term = ((term * t) >> 30) / n;
      m += term;
    end
    prod = {32'd0, s0} * m;
    sh   = 30 - k;
    if (prod == 0 || sh >= 64) return 32'd0;
    if (sh > 0) begin
      prod = prod >> sh;
    end else if (sh < 0) begin
      if (-sh >= 32 || prod > (64'hFFFF_FFFF >> (-sh))) begin
        sat = 1'b1;
        return 32'hFFFF_FFFF;
      end
      prod = prod << (-sh);
    end
    if (prod > 64'hFFFF_FFFF) begin
      sat = 1'b1;
      return 32'hFFFF_FFFF;
    end
    return prod[31:0];
  endfunction

  // Advance the pricer by one accepted noise item; queue a result at batch end.
  task automatic advance_pricer(input logic signed [23:0] noise);
    longint        inc, sum;
    int unsigned   lim;
    bit [31:0]     price, payoff;
    bit            psat;
    bit [63:0]     pv;
    batch_result_t r;
    inc = (longint'(vol) * longint'(noise)) >>> 16;
    inc += longint'($signed(drift));
    sum = longint'(log_sum) + inc;
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    log_sum = int'(sum);
    lim = (steps_cfg == 0) ? 1 : steps_cfg;
    if (lim > STEP_CAP) lim = STEP_CAP;
    step_cnt++;
    if (step_cnt < lim) return;
    price = terminal_price(spot, log_sum, psat);
    if (opt_call) payoff = (price > strike) ? price - strike : 32'd0;
    else payoff = (strike > price) ? strike - price : 32'd0;
    if (psat) sat_sticky = 1'b1;
    if (payoff_acc > TOTAL_CAP - payoff) begin
      payoff_acc = TOTAL_CAP;
      sat_sticky = 1'b1;
    end else begin
      payoff_acc += payoff;
    end
    log_sum = 0;
    step_cnt = 0;
    lim = (paths_cfg == 0) ? 1 : paths_cfg;
    if (lim > PATH_CAP) lim = PATH_CAP;
    path_cnt++;
    if (path_cnt < lim) return;
    pv = ((payoff_acc / path_cnt) * discount) >> 16;
    if (pv > 64'hFFFF_FFFF) begin
      pv = 64'hFFFF_FFFF;
      sat_sticky = 1'b1;
    end
    r.present_value = pv[31:0];
    r.saturated     = sat_sticky;
    pv_expected_q.push_back(r);
    path_cnt = 0;
    payoff_acc = 0;
    sat_sticky = 1'b0;
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Write one register; call at a rising edge, returns at a rising edge.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_OPTION_IS_CALL:  opt_call  = val[0];
      REG_STRIKE_PRICE:    strike    = val;
      REG_SPOT_PRICE:      spot      = val;
      REG_DRIFT_PER_STEP:  drift     = val[23:0];
      REG_VOLATILITY:      vol       = val[17:0];
      REG_STEPS_PER_PATH:  steps_cfg = val[12:0];
      REG_PATH_COUNT:      paths_cfg = val[20:0];
      REG_DISCOUNT_FACTOR: discount  = val[16:0];
      default: ;
    endcase
  endtask

  // Send one noise item; call at a rising edge, returns at a rising edge.
  task automatic send_noise(input logic signed [23:0] v);
    int g;
    in_valid        <= 1'b1;
    in_noise_sample <= v;
    // in_ready is settled by the falling edge; the accept is at the next rise
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    advance_pricer(v);
    g = sender_quiet ? 0 : pick_gap();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Hold off input until every expected result is in, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pv_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [23:0] rand_noise();
    if ($urandom_range(1)) return 24'($urandom);
    return 24'($signed(17'($urandom)));   // small, either sign
  endfunction

  // Result side: random stalls, mostly short.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (sink_quiet) begin
      out_ready <= 1'b1;
    end else if (sink_stall_left > 0) begin
      sink_stall_left = sink_stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      sink_stall_left = pick_gap();
      out_ready <= (sink_stall_left == 0);
    end
  end

  // Check each result; outputs are stable at the falling edge before the accept.
  always @(negedge clk) begin
    batch_result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pv_expected_q.size() == 0) begin
        $error("unexpected result item: present_value %0h", out_present_value);
        fail_count++;
      end else begin
        e = pv_expected_q.pop_front();
        if (out_present_value !== e.present_value) begin
          $error("present_value: expected %0h, got %0h", e.present_value,
                 out_present_value);
          fail_count++;
        end
        if (out_saturated !== e.saturated) begin
          $error("saturated: expected %0b, got %0b", e.saturated, out_saturated);
          fail_count++;
        end
      end
    end
  end

  // Default spot/strike and drift, both payoffs, noise extremes.
  task automatic test_noise_extremes();
    logic signed [23:0] vals[10] = '{24'sd0, 24'sh7FFFFF, -24'sh800000, 24'sd1, -24'sd1,
                                     24'sh555555, -24'sh2AAAAB, 24'sh100000, -24'sh100000,
                                     24'sd4096};
    write_reg(REG_STEPS_PER_PATH, 1);
    write_reg(REG_PATH_COUNT, 2);
    foreach (vals[i]) send_noise(vals[i]);
    drain();
    write_reg(REG_OPTION_IS_CALL, 0);
    foreach (vals[i]) send_noise(vals[i]);
    drain();
  endtask

  // Push the price into saturation and sweep strike and discount extremes.
  task automatic test_price_saturation();
    write_reg(REG_OPTION_IS_CALL, 1);
    write_reg(REG_SPOT_PRICE, 32'hFFFF_FFFF);
    write_reg(REG_STRIKE_PRICE, 0);
    write_reg(REG_DRIFT_PER_STEP, 32'h007F_FFFF);
    write_reg(REG_VOLATILITY, 32'h3FFFF);
    write_reg(REG_DISCOUNT_FACTOR, 65536);
    write_reg(REG_STEPS_PER_PATH, 2);
    write_reg(REG_PATH_COUNT, 1);
    send_noise(24'sh7FFFFF);
    send_noise(24'sh7FFFFF);
    send_noise(-24'sh800000);
    send_noise(-24'sh800000);
    drain();
    write_reg(REG_OPTION_IS_CALL, 0);
    write_reg(REG_STRIKE_PRICE, 32'hFFFF_FFFF);
    write_reg(REG_DISCOUNT_FACTOR, 0);
    send_noise(24'sh7FFFFF);
    send_noise(24'sh7FFFFF);
    drain();
    write_reg(REG_DISCOUNT_FACTOR, 131071);   // field maximum, past 1.0
    send_noise(-24'sh800000);
    send_noise(24'sd0);
    drain();
  endtask

  // Zero step and path counts, and an oversized step count.
  task automatic test_count_limits();
    write_reg(REG_SPOT_PRICE, 6553600);
    write_reg(REG_STRIKE_PRICE, 6000000);
    write_reg(REG_DRIFT_PER_STEP, 47);
    write_reg(REG_VOLATILITY, 13107);
    write_reg(REG_DISCOUNT_FACTOR, 62339);
    write_reg(REG_OPTION_IS_CALL, 1);
    write_reg(REG_STEPS_PER_PATH, 0);
    write_reg(REG_PATH_COUNT, 0);
    repeat (3) send_noise(rand_noise());
    drain();
    // 8191 steps: a long path stays open, then a lowered limit closes it
    write_reg(REG_STEPS_PER_PATH, 13'h1FFF);
    write_reg(REG_PATH_COUNT, 1);
    sender_quiet = 1'b1;
    repeat (300) send_noise(24'($signed(12'($urandom))));
    sender_quiet = 1'b0;
    drain();
    write_reg(REG_STEPS_PER_PATH, 1);
    send_noise(rand_noise());
    drain();
  endtask

  // Lower the limits while a path and a batch are open.
  task automatic test_lowered_limits();
    write_reg(REG_STEPS_PER_PATH, 4);
    write_reg(REG_PATH_COUNT, 21'h1FFFFF);
    repeat (10) send_noise(rand_noise());
    drain();
    write_reg(REG_STEPS_PER_PATH, 1);
    write_reg(REG_PATH_COUNT, 1);
    send_noise(rand_noise());
    drain();
  endtask

  // Random settings per phase, random noise within each.
  task automatic test_random_batches();
    int sent;
    sent = 0;
    while (sent < 560) begin
      if ($urandom_range(3) == 0) begin
        write_reg(REG_SPOT_PRICE, $urandom);
        write_reg(REG_STRIKE_PRICE, $urandom);
        write_reg(REG_DRIFT_PER_STEP, $urandom);
        write_reg(REG_VOLATILITY, $urandom);
        write_reg(REG_DISCOUNT_FACTOR, $urandom_range(131071));
      end else begin
        write_reg(REG_SPOT_PRICE, $urandom_range(32'h00C8_0000, 32'h0001_0000));
        write_reg(REG_STRIKE_PRICE, $urandom_range(32'h00C8_0000, 32'h0001_0000));
        write_reg(REG_DRIFT_PER_STEP, 32'($signed(12'($urandom))));
        write_reg(REG_VOLATILITY, $urandom_range(40000));
        write_reg(REG_DISCOUNT_FACTOR, $urandom_range(65536, 50000));
      end
      write_reg(REG_OPTION_IS_CALL, $urandom);
      write_reg(REG_STEPS_PER_PATH, $urandom_range(8));
      write_reg(REG_PATH_COUNT, $urandom_range(6));
      sender_quiet = ($urandom_range(4) == 0);
      sink_quiet   = ($urandom_range(4) == 0);
      repeat ($urandom_range(80, 30)) begin
        send_noise(rand_noise());
        sent++;
      end
      drain();
    end
    sender_quiet = 1'b0;
    sink_quiet   = 1'b0;
  endtask

  initial begin
    log_sum = 0;
    step_cnt = 0;
    path_cnt = 0;
    payoff_acc = '0;
    sat_sticky = 1'b0;
    fail_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_noise_extremes();
    test_price_saturation();
    test_count_limits();
    test_lowered_limits();
    test_random_batches();
    drain();
    if (fail_count == 0) begin
      $display("tb_gbm_european_option_pricer OK");
    end else begin
      $display("tb_gbm_european_option_pricer NOT OK");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #200ms;
    $display("tb_gbm_european_option_pricer NOT OK");
    $finish;
  end

endmodule

@@ gbm_european_option_pricer.f @@
hw/rtl/gbmeo_pkg.sv
hw/rtl/gbmeo_div.sv
hw/rtl/gbmeo_ctrl.sv
hw/rtl/gbmeo_dp.sv
hw/rtl/gbm_european_option_pricer.sv
hw/rtl/gbmeo_checker.sv
dv/tb_gbm_european_option_pricer.sv
